[src/cbae_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and probability tables for the CABAC arithmetic encoder.
package cbae_pkg;

    localparam logic [1:0] OP_REGULAR   = 2'd0;
    localparam logic [1:0] OP_TERMINATE = 2'd1;
    localparam logic [1:0] OP_INIT      = 2'd2;

    localparam int unsigned OUTST_W   = 16;
    localparam int unsigned CAP_BITS  = (OUTST_W >= 16) ? 16 : OUTST_W;
    localparam logic [OUTST_W-1:0] OUTST_CAP = OUTST_W'((64'd1 << CAP_BITS) - 64'd1);

    localparam int unsigned MAX_EVENTS = 10;
    localparam int unsigned EV_IDX_W   = $clog2(MAX_EVENTS);
    localparam int unsigned EV_CNT_W   = $clog2(MAX_EVENTS + 1);

    localparam logic [8:0] RANGE_INIT  = 9'd510;
    localparam logic [8:0] RANGE_TERM  = 9'd2;
    localparam logic [5:0] ST_MAX_MPS  = 6'd62;

    typedef struct packed {
        logic [1:0] op;
        logic       bin;
        logic [5:0] st;
        logic       split_low;
        logic [5:0] next_st;
        logic       next_mps;
    } item_t;

    typedef struct packed {
        logic [1:0]  bits;
        logic [1:0]  len;
        logic        rbit;
        logic [15:0] rcnt;
    } ev_t;

    localparam logic [7:0] LPS_TAB [64][4] = '{
        '{8'd128, 8'd176, 8'd208, 8'd240}, '{8'd128, 8'd167, 8'd197, 8'd227},
        '{8'd128, 8'd158, 8'd187, 8'd216}, '{8'd123, 8'd150, 8'd178, 8'd205},
        '{8'd116, 8'd142, 8'd169, 8'd195}, '{8'd111, 8'd135, 8'd160, 8'd185},
        '{8'd105, 8'd128, 8'd152, 8'd175}, '{8'd100, 8'd122, 8'd144, 8'd166},
        '{8'd95,  8'd116, 8'd137, 8'd158}, '{8'd90,  8'd110, 8'd130, 8'd150},
        '{8'd85,  8'd104, 8'd123, 8'd142}, '{8'd81,  8'd99,  8'd117, 8'd135},
        '{8'd77,  8'd94,  8'd111, 8'd128}, '{8'd73,  8'd89,  8'd105, 8'd122},
        '{8'd69,  8'd85,  8'd100, 8'd116}, '{8'd66,  8'd80,  8'd95,  8'd110},
        '{8'd62,  8'd76,  8'd90,  8'd104}, '{8'd59,  8'd72,  8'd86,  8'd99},
        '{8'd56,  8'd69,  8'd81,  8'd94},  '{8'd53,  8'd65,  8'd77,  8'd89},
        '{8'd51,  8'd62,  8'd73,  8'd85},  '{8'd48,  8'd59,  8'd69,  8'd80},
        '{8'd46,  8'd56,  8'd66,  8'd76},  '{8'd43,  8'd53,  8'd63,  8'd72},
        '{8'd41,  8'd50,  8'd59,  8'd69},  '{8'd39,  8'd48,  8'd56,  8'd65},
        '{8'd37,  8'd45,  8'd54,  8'd62},  '{8'd35,  8'd43,  8'd51,  8'd59},
        '{8'd33,  8'd41,  8'd48,  8'd56},  '{8'd32,  8'd39,  8'd46,  8'd53},
        '{8'd30,  8'd37,  8'd43,  8'd50},  '{8'd29,  8'd35,  8'd41,  8'd48},
        '{8'd27,  8'd33,  8'd39,  8'd45},  '{8'd26,  8'd31,  8'd37,  8'd43},
        '{8'd24,  8'd30,  8'd35,  8'd41},  '{8'd23,  8'd28,  8'd33,  8'd39},
        '{8'd22,  8'd27,  8'd32,  8'd37},  '{8'd21,  8'd26,  8'd30,  8'd35},
        '{8'd20,  8'd24,  8'd29,  8'd33},  '{8'd19,  8'd23,  8'd27,  8'd31},
        '{8'd18,  8'd22,  8'd26,  8'd30},  '{8'd17,  8'd21,  8'd25,  8'd28},
        '{8'd16,  8'd20,  8'd23,  8'd27},  '{8'd15,  8'd19,  8'd22,  8'd25},
        '{8'd14,  8'd18,  8'd21,  8'd24},  '{8'd14,  8'd17,  8'd20,  8'd23},
        '{8'd13,  8'd16,  8'd19,  8'd22},  '{8'd12,  8'd15,  8'd18,  8'd21},
        '{8'd12,  8'd14,  8'd17,  8'd20},  '{8'd11,  8'd14,  8'd16,  8'd19},
        '{8'd11,  8'd13,  8'd15,  8'd18},  '{8'd10,  8'd12,  8'd15,  8'd17},
        '{8'd10,  8'd12,  8'd14,  8'd16},  '{8'd9,   8'd11,  8'd13,  8'd15},
        '{8'd9,   8'd11,  8'd12,  8'd14},  '{8'd8,   8'd10,  8'd12,  8'd14},
        '{8'd8,   8'd9,   8'd11,  8'd13},  '{8'd7,   8'd9,   8'd11,  8'd12},
        '{8'd7,   8'd9,   8'd10,  8'd12},  '{8'd7,   8'd8,   8'd10,  8'd11},
        '{8'd6,   8'd8,   8'd9,   8'd11},  '{8'd6,   8'd7,   8'd9,   8'd10},
        '{8'd6,   8'd7,   8'd8,   8'd9},   '{8'd2,   8'd2,   8'd2,   8'd2}
    };

    localparam logic [5:0] TRANS_LPS [64] = '{
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
        6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
        6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
        6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
        6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
    };

endpackage

[src/cabac_binary_arithmetic_encoder_core.sv]
`timescale 1ns / 1ps
// CABAC arithmetic encoder top: two-entry bin queue feeding the coding engine.
// The engine FSM takes one queued bin at a time: range split, renormalization shifts,
// a terminate flush when needed, then the result beats; the queue accepts up to two more
// bins while the engine is busy.
// Reset: range 510, low 0, first bit pending, outstanding and bin counts 0, queue empty.
module cabac_binary_arithmetic_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        bin,
    input  logic [5:0]  ctx_state,
    input  logic        ctx_mps,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  emit_bits,
    output logic [1:0]  emit_len,
    output logic        repeat_bit,
    output logic [15:0] repeat_count,
    output logic [5:0]  next_ctx_state,
    output logic        next_ctx_mps,
    output logic        saturated,
    output logic [31:0] bin_total,
    output logic        last
);
    import cbae_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    cbae_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .bin       (bin),
        .ctx_state (ctx_state),
        .ctx_mps   (ctx_mps),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    cbae_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .emit_bits      (emit_bits),
        .emit_len       (emit_len),
        .repeat_bit     (repeat_bit),
        .repeat_count   (repeat_count),
        .next_ctx_state (next_ctx_state),
        .next_ctx_mps   (next_ctx_mps),
        .saturated      (saturated),
        .bin_total      (bin_total),
        .last           (last)
    );

endmodule

[src/cbae_front.sv]
`timescale 1ns / 1ps
// Input side: classifies each bin, updates its context and queues it for the engine.
module cbae_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      operation,
    input  logic            bin,
    input  logic [5:0]      ctx_state,
    input  logic            ctx_mps,
    output logic            q_valid,
    output cbae_pkg::item_t q_item,
    input  logic            q_pop
);
    import cbae_pkg::*;

    localparam logic [1:0] Q_DEPTH = 2'd2;

    item_t      slot_reg [2];
    item_t      cls;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;

    always_comb
    begin
        cls.op       = operation;
        cls.bin      = bin;
        cls.st       = ctx_state;
        cls.split_low = 1'b0;
        cls.next_st  = ctx_state;
        cls.next_mps = ctx_mps;
        case (operation)
            OP_REGULAR:
            begin
                cls.split_low = bin ^ ctx_mps;
                if (bin != ctx_mps)
                begin
                    cls.next_st  = TRANS_LPS[ctx_state];
                    cls.next_mps = ctx_mps ^ (ctx_state == 6'd0);
                end
                else if (ctx_state < ST_MAX_MPS)
                begin
                    cls.next_st = ctx_state + 6'd1;
                end
            end
            OP_TERMINATE:
            begin
                cls.split_low = bin;
            end
            default:
            begin
                cls.split_low = 1'b0;
            end
        endcase
    end

    assign in_ready = (count_reg != Q_DEPTH);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[src/cbae_back.sv]
`timescale 1ns / 1ps
// Engine side: init, range split, renormalization, flush and result beat delivery.
module cbae_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cbae_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      emit_bits,
    output logic [1:0]      emit_len,
    output logic            repeat_bit,
    output logic [15:0]     repeat_count,
    output logic [5:0]      next_ctx_state,
    output logic            next_ctx_mps,
    output logic            saturated,
    output logic [31:0]     bin_total,
    output logic            last
);
    import cbae_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RENORM, S_TERM, S_FLUSH, S_DRAIN} state_t;

    state_t              state_reg, state_next;
    logic [8:0]          range_reg, range_next;
    logic [9:0]          low_reg, low_next;
    logic                first_reg, first_next;
    logic [OUTST_W-1:0]  outst_reg, outst_next;
    logic [31:0]         bincnt_reg, bincnt_next;
    logic                sat_reg, sat_next;
    logic                term_flush_reg, term_flush_next;
    logic [5:0]          nst_reg, nst_next;
    logic                nmps_reg, nmps_next;
    logic [EV_CNT_W-1:0] evn_reg, evn_next;
    logic [EV_IDX_W-1:0] rd_reg, rd_next;
    logic                out_valid_reg, out_valid_next;
    ev_t                 out_ev_reg, out_ev_next;
    logic [5:0]          out_st_reg, out_st_next;
    logic                out_mps_reg, out_mps_next;
    logic                out_sat_reg, out_sat_next;
    logic [31:0]         out_total_reg, out_total_next;
    logic                out_last_reg, out_last_next;

    ev_t                 ev_buf [MAX_EVENTS];
    logic                ev_we;
    logic [EV_IDX_W-1:0] ev_idx;
    ev_t                 ev_data;

    logic [7:0]          lps;
    logic [8:0]          r_sub;
    logic [8:0]          r_split;
    logic [9:0]          low_t;
    logic                put_req;
    logic                put_b;
    logic [EV_IDX_W-1:0] last_idx;
    logic                is_term_one;

    assign lps = LPS_TAB[q_item.st][range_reg[7:6]];
    assign r_sub = range_reg - ((q_item.op == OP_REGULAR) ? {1'b0, lps} : RANGE_TERM);
    assign r_split = !q_item.split_low ? r_sub :
                     (q_item.op == OP_REGULAR) ? {1'b0, lps} : RANGE_TERM;
    assign is_term_one = (q_item.op == OP_TERMINATE) && q_item.bin;
    assign last_idx = (evn_reg == '0) ? '0 : EV_IDX_W'(evn_reg - 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        range_next      = range_reg;
        low_next        = low_reg;
        first_next      = first_reg;
        outst_next      = outst_reg;
        bincnt_next     = bincnt_reg;
        sat_next        = sat_reg;
        term_flush_next = term_flush_reg;
        nst_next        = nst_reg;
        nmps_next       = nmps_reg;
        evn_next        = evn_reg;
        rd_next         = rd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_ev_next     = out_ev_reg;
        out_st_next     = out_st_reg;
        out_mps_next    = out_mps_reg;
        out_sat_next    = out_sat_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        ev_we           = 1'b0;
        ev_idx          = evn_reg[EV_IDX_W-1:0];
        ev_data         = '0;
        put_req         = 1'b0;
        put_b           = 1'b0;
        low_t           = low_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    nst_next        = q_item.next_st;
                    nmps_next       = q_item.next_mps;
                    term_flush_next = is_term_one;
                    evn_next        = '0;
                    rd_next         = '0;
                    sat_next        = 1'b0;
                    ev_we           = 1'b1;
                    ev_idx          = '0;
                    ev_data         = '0;
                    state_next      = S_DRAIN;
                    case (q_item.op)
                        OP_REGULAR, OP_TERMINATE:
                        begin
                            bincnt_next = bincnt_reg + 32'd1;
                            range_next  = r_split;
                            if (q_item.split_low)
                            begin
                                low_next = low_reg + {1'b0, r_sub};
                            end
                            if (!r_split[8] && (r_split != 9'd0))
                            begin
                                state_next = S_RENORM;
                            end
                            else if (is_term_one)
                            begin
                                state_next = S_TERM;
                            end
                        end
                        OP_INIT:
                        begin
                            range_next  = RANGE_INIT;
                            low_next    = '0;
                            first_next  = 1'b1;
                            outst_next  = '0;
                            bincnt_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DRAIN;
                        end
                    endcase
                end
            end
            S_RENORM:
            begin
                if (!low_reg[9] && !low_reg[8])
                begin
                    put_req = 1'b1;
                    put_b   = 1'b0;
                end
                else if (low_reg[9])
                begin
                    low_t   = {1'b0, low_reg[8:0]};
                    put_req = 1'b1;
                    put_b   = 1'b1;
                end
                else
                begin
                    low_t = {2'b00, low_reg[7:0]};
                    if (outst_reg < OUTST_CAP)
                    begin
                        outst_next = outst_reg + 1'b1;
                    end
                    else
                    begin
                        sat_next = 1'b1;
                    end
                end
                range_next = {range_reg[7:0], 1'b0};
                low_next   = {low_t[8:0], 1'b0};
                if (!range_reg[7] && (range_reg[7:0] != 8'd0))
                begin
                    state_next = S_RENORM;
                end
                else if (term_flush_reg)
                begin
                    state_next = S_TERM;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_TERM:
            begin
                put_req    = 1'b1;
                put_b      = low_reg[9];
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (evn_reg < EV_CNT_W'(MAX_EVENTS))
                begin
                    ev_we    = 1'b1;
                    ev_data  = '{bits: low_reg[8:7] | 2'b01, len: 2'd2, rbit: 1'b0,
                                 rcnt: 16'd0};
                    evn_next = evn_reg + 1'b1;
                end
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ev_next    = ev_buf[rd_reg];
                    out_st_next    = nst_reg;
                    out_mps_next   = nmps_reg;
                    out_sat_next   = sat_reg;
                    out_total_next = bincnt_reg;
                    out_last_next  = (rd_reg == last_idx);
                    rd_next        = rd_reg + 1'b1;
                    if (rd_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (put_req)
        begin
            first_next = 1'b0;
            outst_next = '0;
            if (evn_reg < EV_CNT_W'(MAX_EVENTS))
            begin
                ev_we    = 1'b1;
                ev_data  = '{bits: first_reg ? 2'b00 : {1'b0, put_b},
                             len: first_reg ? 2'd0 : 2'd1,
                             rbit: ~put_b, rcnt: 16'(outst_reg)};
                evn_next = evn_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            range_reg      <= RANGE_INIT;
            low_reg        <= '0;
            first_reg      <= 1'b1;
            outst_reg      <= '0;
            bincnt_reg     <= '0;
            sat_reg        <= 1'b0;
            term_flush_reg <= 1'b0;
            evn_reg        <= '0;
            rd_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            range_reg      <= range_next;
            low_reg        <= low_next;
            first_reg      <= first_next;
            outst_reg      <= outst_next;
            bincnt_reg     <= bincnt_next;
            sat_reg        <= sat_next;
            term_flush_reg <= term_flush_next;
            evn_reg        <= evn_next;
            rd_reg         <= rd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nst_reg       <= nst_next;
        nmps_reg      <= nmps_next;
        out_ev_reg    <= out_ev_next;
        out_st_reg    <= out_st_next;
        out_mps_reg   <= out_mps_next;
        out_sat_reg   <= out_sat_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
        if (ev_we)
        begin
            ev_buf[ev_idx] <= ev_data;
        end
    end

    assign out_valid      = out_valid_reg;
    assign emit_bits      = out_ev_reg.bits;
    assign emit_len       = out_ev_reg.len;
    assign repeat_bit     = out_ev_reg.rbit;
    assign repeat_count   = out_ev_reg.rcnt;
    assign next_ctx_state = out_st_reg;
    assign next_ctx_mps   = out_mps_reg;
    assign saturated      = out_sat_reg;
    assign bin_total      = out_total_reg;
    assign last           = out_last_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the CABAC arithmetic encoder core with a bit-exact engine predictor.
module tb;
    import cbae_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [15:0] OUTST_MAX    = 16'hFFFF;
    localparam int          MAX_BEATS    = 10;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 30;
    localparam int          RANDOM_ITEMS = 150;
    localparam int          STEER_ITEMS  = 14;

    localparam logic [7:0] LPS_RANGE [64][4] = '{
        '{128, 176, 208, 240}, '{128, 167, 197, 227}, '{128, 158, 187, 216}, '{123, 150, 178, 205},
        '{116, 142, 169, 195}, '{111, 135, 160, 185}, '{105, 128, 152, 175}, '{100, 122, 144, 166},
        '{95, 116, 137, 158},  '{90, 110, 130, 150},  '{85, 104, 123, 142},  '{81, 99, 117, 135},
        '{77, 94, 111, 128},   '{73, 89, 105, 122},   '{69, 85, 100, 116},   '{66, 80, 95, 110},
        '{62, 76, 90, 104},    '{59, 72, 86, 99},     '{56, 69, 81, 94},     '{53, 65, 77, 89},
        '{51, 62, 73, 85},     '{48, 59, 69, 80},     '{46, 56, 66, 76},     '{43, 53, 63, 72},
        '{41, 50, 59, 69},     '{39, 48, 56, 65},     '{37, 45, 54, 62},     '{35, 43, 51, 59},
        '{33, 41, 48, 56},     '{32, 39, 46, 53},     '{30, 37, 43, 50},     '{29, 35, 41, 48},
        '{27, 33, 39, 45},     '{26, 31, 37, 43},     '{24, 30, 35, 41},     '{23, 28, 33, 39},
        '{22, 27, 32, 37},     '{21, 26, 30, 35},     '{20, 24, 29, 33},     '{19, 23, 27, 31},
        '{18, 22, 26, 30},     '{17, 21, 25, 28},     '{16, 20, 23, 27},     '{15, 19, 22, 25},
        '{14, 18, 21, 24},     '{14, 17, 20, 23},     '{13, 16, 19, 22},     '{12, 15, 18, 21},
        '{12, 14, 17, 20},     '{11, 14, 16, 19},     '{11, 13, 15, 18},     '{10, 12, 15, 17},
        '{10, 12, 14, 16},     '{9, 11, 13, 15},      '{9, 11, 12, 14},      '{8, 10, 12, 14},
        '{8, 9, 11, 13},       '{7, 9, 11, 12},       '{7, 9, 10, 12},       '{7, 8, 10, 11},
        '{6, 8, 9, 11},        '{6, 7, 9, 10},        '{6, 7, 8, 9},         '{2, 2, 2, 2}
    };

    localparam logic [5:0] LPS_NEXT [64] = '{
        0,  0,  1,  2,  2,  4,  4,  5,  6,  7,  8,  9,  9,  11, 11, 12,
        13, 13, 15, 15, 16, 16, 18, 18, 19, 19, 21, 21, 22, 22, 23, 24,
        24, 25, 26, 26, 27, 27, 28, 29, 29, 30, 30, 30, 31, 32, 32, 33,
        33, 33, 34, 34, 35, 35, 35, 36, 36, 36, 37, 37, 37, 38, 38, 63
    };

    typedef struct packed {
        logic [1:0]  bits;
        logic [1:0]  len;
        logic        rbit;
        logic [15:0] rcnt;
        logic [5:0]  st;
        logic        mps;
        logic        sat;
        logic [31:0] total;
        logic        last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic        bin;
    logic [5:0]  ctx_state;
    logic        ctx_mps;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  emit_bits;
    logic [1:0]  emit_len;
    logic        repeat_bit;
    logic [15:0] repeat_count;
    logic [5:0]  next_ctx_state;
    logic        next_ctx_mps;
    logic        saturated;
    logic [31:0] bin_total;
    logic        last;

    // engine copy
    logic [8:0]  enc_range;
    logic [9:0]  enc_low;
    logic        enc_first;
    logic [15:0] enc_outst;
    logic [31:0] enc_bins;
    logic        drop_seen;
    logic [5:0]  coded_st;
    logic        coded_mps;

    beat_t       pending_beats[$];
    beat_t       expected_beats[$];

    bit          idle_on;
    bit          hold_req;
    int          hold_left;
    int          cycle_count;
    int          errors;
    int          items_sent;
    int          beats_seen;
    int          flushes;
    int          drops;

    cabac_binary_arithmetic_encoder_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .bin            (bin),
        .ctx_state      (ctx_state),
        .ctx_mps        (ctx_mps),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .emit_bits      (emit_bits),
        .emit_len       (emit_len),
        .repeat_bit     (repeat_bit),
        .repeat_count   (repeat_count),
        .next_ctx_state (next_ctx_state),
        .next_ctx_mps   (next_ctx_mps),
        .saturated      (saturated),
        .bin_total      (bin_total),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void reset_engine();
        enc_range = 9'd510;
        enc_low   = 10'd0;
        enc_first = 1'b1;
        enc_outst = 16'd0;
        enc_bins  = 32'd0;
    endfunction

    function automatic void write_bit(logic b);
        beat_t e;
        e      = '0;
        e.bits = enc_first ? 2'd0 : {1'b0, b};
        e.len  = enc_first ? 2'd0 : 2'd1;
        e.rbit = ~b;
        e.rcnt = enc_outst;
        enc_first = 1'b0;
        enc_outst = 16'd0;
        if (pending_beats.size() < MAX_BEATS)
            pending_beats.push_back(e);
    endfunction

    function automatic void renormalize();
        while (!enc_range[8] && enc_range != 9'd0)
        begin
            if (enc_low < 10'd256)
                write_bit(1'b0);
            else if (enc_low >= 10'd512)
            begin
                enc_low = enc_low - 10'd512;
                write_bit(1'b1);
            end
            else
            begin
                enc_low = enc_low - 10'd256;
                if (enc_outst < OUTST_MAX)
                    enc_outst = enc_outst + 16'd1;
                else
                    drop_seen = 1'b1;
            end
            enc_range = enc_range << 1;
            enc_low   = enc_low << 1;
        end
    endfunction

    // Advances the engine copy by one command and queues the beats it must produce.
    function automatic void code_bin(logic [1:0] op, logic b, logic [5:0] s, logic m);
        logic [7:0] lps;
        logic [5:0] st;
        logic       mps;
        beat_t      e;
        pending_beats.delete();
        drop_seen = 1'b0;
        st  = s;
        mps = m;
        case (op)
            OP_REGULAR:
            begin
                lps = LPS_RANGE[s][enc_range[7:6]];
                enc_range = enc_range - {1'b0, lps};
                if (b != m)
                begin
                    enc_low   = enc_low + {1'b0, enc_range};
                    enc_range = {1'b0, lps};
                    if (s == 6'd0)
                        mps = ~mps;
                    st = LPS_NEXT[s];
                end
                else if (s < 6'd62)
                    st = s + 6'd1;
                renormalize();
                enc_bins = enc_bins + 32'd1;
            end
            OP_TERMINATE:
            begin
                enc_range = enc_range - 9'd2;
                if (b)
                begin
                    enc_low   = enc_low + {1'b0, enc_range};
                    enc_range = 9'd2;
                    renormalize();
                    write_bit(enc_low[9]);
                    e      = '0;
                    e.bits = enc_low[8:7] | 2'b01;
                    e.len  = 2'd2;
                    if (pending_beats.size() < MAX_BEATS)
                        pending_beats.push_back(e);
                    flushes++;
                end
                else
                    renormalize();
                enc_bins = enc_bins + 32'd1;
            end
            OP_INIT:
                reset_engine();
            default:
                ;
        endcase
        if (pending_beats.size() == 0)
        begin
            e = '0;
            pending_beats.push_back(e);
        end
        foreach (pending_beats[k])
        begin
            e       = pending_beats[k];
            e.st    = st;
            e.mps   = mps;
            e.sat   = drop_seen;
            e.total = enc_bins;
            e.last  = (k == pending_beats.size() - 1);
            expected_beats.push_back(e);
        end
        if (drop_seen)
            drops++;
        coded_st  = st;
        coded_mps = mps;
    endfunction

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    task automatic push_bin(input logic [1:0] op, input logic b, input logic [5:0] s,
                            input logic m);
        int gap;
        gap = (idle_on && $urandom_range(99) < 25) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = op;
        bin       = b;
        ctx_state = s;
        ctx_mps   = m;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        code_bin(op, b, s, m);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        push_bin(OP_INIT, 1'b0, 6'd0, 1'b0);
        push_bin(OP_REGULAR, 1'b0, 6'd0, 1'b0);
        push_bin(OP_REGULAR, 1'b1, 6'd0, 1'b0);
        push_bin(OP_REGULAR, 1'b1, 6'd63, 1'b1);
        push_bin(OP_REGULAR, 1'b0, 6'd63, 1'b1);
        push_bin(OP_REGULAR, 1'b1, 6'd62, 1'b1);
        push_bin(OP_REGULAR, 1'b0, 6'd62, 1'b1);
        push_bin(OP_REGULAR, 1'b0, 6'd0, 1'b1);
        push_bin(OP_REGULAR, 1'b0, 6'd31, 1'b0);
        push_bin(OP_UNUSED, 1'b1, 6'd63, 1'b1);
        push_bin(OP_TERMINATE, 1'b0, 6'd63, 1'b1);
        push_bin(OP_TERMINATE, 1'b1, 6'd0, 1'b0);
        push_bin(OP_INIT, 1'b1, 6'd63, 1'b1);
        // flush straight after init: the first bit is swallowed
        push_bin(OP_TERMINATE, 1'b1, 6'd42, 1'b1);
        push_bin(OP_REGULAR, 1'b1, 6'd63, 1'b0);
        push_bin(OP_UNUSED, 1'b0, 6'd0, 1'b0);
        push_bin(OP_REGULAR, 1'b0, 6'd12, 1'b0);
        push_bin(OP_TERMINATE, 1'b1, 6'd21, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_streams();
        logic [5:0] ctx_st_mem [8];
        logic       ctx_mps_mem [8];
        int         start;
        int         len;
        int         idx;
        logic       b;
        start = items_sent;
        for (int i = 0; i < 8; i++)
        begin
            ctx_st_mem[i]  = 6'($urandom_range(63));
            ctx_mps_mem[i] = 1'($urandom);
        end
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 80)
            begin
                push_bin(OP_INIT, 1'($urandom), 6'($urandom), 1'($urandom));
                len = $urandom_range(4, 24);
                repeat (len)
                begin
                    if ($urandom_range(99) < 8)
                        push_bin(OP_TERMINATE, 1'b0, 6'($urandom), 1'($urandom));
                    else
                    begin
                        idx = $urandom_range(7);
                        b = ($urandom_range(99) < 75) ? ctx_mps_mem[idx] : ~ctx_mps_mem[idx];
                        push_bin(OP_REGULAR, b, ctx_st_mem[idx], ctx_mps_mem[idx]);
                        ctx_st_mem[idx]  = coded_st;
                        ctx_mps_mem[idx] = coded_mps;
                    end
                end
                push_bin(OP_TERMINATE, 1'b1, 6'($urandom), 1'($urandom));
            end
            else
            begin
                repeat (3)
                    push_bin(2'($urandom), 1'($urandom), 6'($urandom), 1'($urandom));
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        repeat (24)
            push_bin(OP_REGULAR, 1'($urandom), 6'($urandom), 1'($urandom));
        push_bin(OP_TERMINATE, 1'b1, 6'($urandom), 1'($urandom));
        wait_idle();
        idle_on = 1'b1;
    endtask

    // Steers the coding interval to straddle the midpoint where it can, so shifts add
    // outstanding bits and build long outstanding runs; then flushes.
    task automatic test_outstanding_runs();
        int   lo;
        int   hi;
        int   cut;
        int   best;
        int   best_s;
        logic best_lps;
        logic m;
        idle_on = 1'b0;
        push_bin(OP_INIT, 1'b0, 6'd0, 1'b0);
        repeat (STEER_ITEMS)
        begin
            lo = int'(enc_low);
            hi = lo + int'(enc_range);
            if (lo < 512 && hi > 512)
            begin
                best     = 1024;
                best_s   = 0;
                best_lps = 1'b0;
                for (int s = 0; s < 64; s++)
                begin
                    cut = hi - int'(LPS_RANGE[s][enc_range[7:6]]);
                    if (cut > 512 && cut - lo < best)
                    begin
                        best     = cut - lo;
                        best_s   = s;
                        best_lps = 1'b0;
                    end
                    else if (cut < 512 && hi - cut < best)
                    begin
                        best     = hi - cut;
                        best_s   = s;
                        best_lps = 1'b1;
                    end
                end
                m = 1'($urandom);
                push_bin(OP_REGULAR, best_lps ? ~m : m, 6'(best_s), m);
            end
            else
                push_bin(OP_REGULAR, 1'($urandom), 6'($urandom), 1'($urandom));
        end
        push_bin(OP_TERMINATE, 1'b1, 6'd0, 1'b0);
        wait_idle();
        idle_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_ready = 1'b0;
        end
        else
            out_ready = !idle_on || ($urandom_range(99) >= 25);
    end

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {emit_bits, emit_len, repeat_bit, repeat_count, next_ctx_state,
                   next_ctx_mps, saturated, bin_total, last};
            beats_seen++;
            if (expected_beats.size() == 0)
                flag_error($sformatf("result beat with nothing expected: %h", got));
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                    flag_error($sformatf({"beat %0d: exp bits %h len %0d rbit %0d rcnt %0d ",
                        "st %0d mps %0d sat %0d total %0d last %0d / got bits %h len %0d ",
                        "rbit %0d rcnt %0d st %0d mps %0d sat %0d total %0d last %0d"},
                        beats_seen, want.bits, want.len, want.rbit, want.rcnt, want.st,
                        want.mps, want.sat, want.total, want.last, got.bits, got.len,
                        got.rbit, got.rcnt, got.st, got.mps, got.sat, got.total, got.last));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_REGULAR;
        bin        = 1'b0;
        ctx_state  = 6'd0;
        ctx_mps    = 1'b0;
        out_ready  = 1'b0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        hold_left  = 0;
        errors     = 0;
        items_sent = 0;
        beats_seen = 0;
        flushes    = 0;
        drops      = 0;
        reset_engine();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_streams();
        test_backpressure();
        test_outstanding_runs();

        if (expected_beats.size() != 0)
            flag_error($sformatf("%0d expected beats never arrived", expected_beats.size()));
        $display("Run: %0d commands, %0d result beats, %0d flushes, %0d mismatches",
                 items_sent, beats_seen, flushes, errors);
        $display("Covered regular/terminate/init/unused ops, output stall, outstanding runs, %0d capped",
                 drops);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
src/cbae_pkg.sv
src/cbae_front.sv
src/cbae_back.sv
src/cabac_binary_arithmetic_encoder_core.sv
bench/tb.sv
